@@ sv/tofd_pkg.sv @@
// Shared types and constants for the time-of-flight to d-spacing unit.
`timescale 1ns / 1ps
package tofd_pkg;

   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 32;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PIXEL_COUNT        = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MODERATOR_DISTANCE = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TOF_SCALE          = 2'd2;

   localparam logic [31:0] TOF_SCALE_RESET = 32'd1699089;
   localparam logic [31:0] D_SATURATED     = 32'hFFFF_FFFF;

   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_EVENT = 1'b1;

   localparam logic [1:0] STATUS_OK          = 2'd0;
   localparam logic [1:0] STATUS_PIXEL_RANGE = 2'd1;
   localparam logic [1:0] STATUS_ZERO        = 2'd2;

   localparam int SQRT_R_STEPS = 24;
   localparam int DIV_Q_STEPS  = 33;
   localparam int SQRT_S_STEPS = 32;
   localparam int DIV_D_STEPS  = 32;

   typedef struct packed {
      logic valid;
      logic pixel_range;
      logic zero_time;
      logic zero_angle;
   } flags_type;

endpackage

@@ sv/tofd_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module tofd_ram #(
   parameter int WIDTH = 72,
   parameter int DEPTH = 131072
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/tof_event_to_d_spacing_unit.sv @@
// Top level: pipelined conversion of detector events to Bragg d-spacing.
// Throughput: one beat per cycle; the whole pipeline holds while a result waits.
// The depth is set by the bit-per-stage square roots and dividers.
// Synchronous reset clears pipeline valid bits and loads the configuration
// registers; the pixel table holds no reset value and needs no clearing pass.
`timescale 1ns / 1ps
module tof_event_to_d_spacing_unit
   import tofd_pkg::*;
#(
   parameter int MAX_PIXELS = 131072
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_kind,
   input  logic [19:0]                req_pixel_index,
   input  logic [23:0]                req_tof_channel,
   input  logic signed [23:0]         req_pos_x,
   input  logic signed [23:0]         req_pos_y,
   input  logic signed [23:0]         req_pos_z,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [31:0]                rsp_d_spacing,
   output logic [1:0]                 rsp_status,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_write_data
);

   localparam int AW = MAX_PIXELS > 1 ? $clog2(MAX_PIXELS) : 1;
   localparam logic [20:0] MaxPix = 21'(MAX_PIXELS);

   logic        adv;
   logic [17:0] pixel_count_ff;
   logic [23:0] moderator_distance_ff;
   logic [31:0] tof_scale_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_count_ff        <= '0;
         moderator_distance_ff <= '0;
         tof_scale_ff          <= TOF_SCALE_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_PIXEL_COUNT:        pixel_count_ff <= csr_write_data[17:0];
            CSR_MODERATOR_DISTANCE: moderator_distance_ff <= csr_write_data[23:0];
            CSR_TOF_SCALE:          tof_scale_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   logic rsp_valid_ff;
   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;

   logic accept;
   logic in_table;
   assign accept   = req_valid && adv;
   assign in_table = {1'b0, req_pixel_index} < MaxPix;

   logic [71:0] ram_rd_data;

   tofd_ram #(
      .WIDTH(72),
      .DEPTH(MAX_PIXELS)
   ) u_table (
      .clock  (clock),
      .wr_en  (accept && req_kind == KIND_LOAD && in_table),
      .wr_addr(req_pixel_index[AW-1:0]),
      .wr_data({req_pos_x, req_pos_y, req_pos_z}),
      .rd_en  (adv),
      .rd_addr(req_pixel_index[AW-1:0]),
      .rd_data(ram_rd_data)
   );

   // stage 0: table read, range and zero-time checks
   flags_type   p0f_ff, p0f_in;
   logic [23:0] p0ch_ff;

   always_comb begin
      p0f_in.valid       = accept && req_kind == KIND_EVENT;
      p0f_in.pixel_range = !in_table || req_pixel_index >= {2'b0, pixel_count_ff};
      p0f_in.zero_time   = req_tof_channel == '0;
      p0f_in.zero_angle  = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p0f_ff.valid <= 1'b0;
      end else if (adv) begin
         p0f_ff <= p0f_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p0ch_ff <= req_tof_channel;
      end
   end

   // stage 1: squares and numerator
   logic signed [23:0] ram_x, ram_y, ram_z;
   logic signed [47:0] sqx_in, sqy_in, sqz_in;
   logic [55:0]        num_in;
   flags_type          p1f_ff;
   logic [46:0]        p1sqx_ff, p1sqy_ff, p1sqz_ff;
   logic signed [23:0] p1x_ff;
   logic [55:0]        p1num_ff;

   assign ram_x  = ram_rd_data[71:48];
   assign ram_y  = ram_rd_data[47:24];
   assign ram_z  = ram_rd_data[23:0];
   assign sqx_in = ram_x * ram_x;
   assign sqy_in = ram_y * ram_y;
   assign sqz_in = ram_z * ram_z;
   assign num_in = 56'(tof_scale_ff) * 56'(p0ch_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         p1f_ff.valid <= 1'b0;
      end else if (adv) begin
         p1f_ff <= p0f_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p1sqx_ff <= sqx_in[46:0];
         p1sqy_ff <= sqy_in[46:0];
         p1sqz_ff <= sqz_in[46:0];
         p1x_ff   <= ram_x;
         p1num_ff <= num_in;
      end
   end

   // stage 2: radius squared
   flags_type          p2f_ff;
   logic [47:0]        p2r2_ff;
   logic signed [23:0] p2x_ff;
   logic [55:0]        p2num_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p2f_ff.valid <= 1'b0;
      end else if (adv) begin
         p2f_ff <= p1f_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p2r2_ff  <= 48'(p1sqx_ff) + 48'(p1sqy_ff) + 48'(p1sqz_ff);
         p2x_ff   <= p1x_ff;
         p2num_ff <= p1num_ff;
      end
   end

   // radius square root, one result bit per stage
   flags_type          rf_ff   [SQRT_R_STEPS];
   logic [47:0]        rv_ff   [SQRT_R_STEPS];
   logic [47:0]        rr_ff   [SQRT_R_STEPS];
   logic signed [23:0] rx_ff   [SQRT_R_STEPS];
   logic [55:0]        rnum_ff [SQRT_R_STEPS];

   for (genvar k = 0; k < SQRT_R_STEPS; k++) begin : g_sqrt_r
      localparam logic [47:0] Bit = 48'(1) << (46 - 2 * k);
      flags_type          f_prev;
      logic [47:0]        v_prev, r_prev, trial;
      logic [47:0]        v_in, r_in;
      logic signed [23:0] x_prev;
      logic [55:0]        num_prev;

      if (k == 0) begin : g_first
         assign f_prev   = p2f_ff;
         assign v_prev   = p2r2_ff;
         assign r_prev   = '0;
         assign x_prev   = p2x_ff;
         assign num_prev = p2num_ff;
      end else begin : g_next
         assign f_prev   = rf_ff[k-1];
         assign v_prev   = rv_ff[k-1];
         assign r_prev   = rr_ff[k-1];
         assign x_prev   = rx_ff[k-1];
         assign num_prev = rnum_ff[k-1];
      end

      always_comb begin
         trial = r_prev + Bit;
         if (v_prev >= trial) begin
            v_in = v_prev - trial;
            r_in = (r_prev >> 1) + Bit;
         end else begin
            v_in = v_prev;
            r_in = r_prev >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            rf_ff[k].valid <= 1'b0;
         end else if (adv) begin
            rf_ff[k] <= f_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rv_ff[k]   <= v_in;
            rr_ff[k]   <= r_in;
            rx_ff[k]   <= x_prev;
            rnum_ff[k] <= num_prev;
         end
      end
   end

   // stage 3: zero radius check and division setup
   logic [23:0]        r_last;
   logic signed [25:0] rdiff;
   flags_type          p3f_ff, p3f_in;
   logic [23:0]        p3r_ff;
   logic [55:0]        p3rem_ff;
   logic [55:0]        p3num_ff;

   assign r_last = rr_ff[SQRT_R_STEPS-1][23:0];
   assign rdiff  = $signed({2'b0, r_last}) - 26'(rx_ff[SQRT_R_STEPS-1]);

   always_comb begin
      p3f_in = rf_ff[SQRT_R_STEPS-1];
      p3f_in.zero_angle = r_last == '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p3f_ff.valid <= 1'b0;
      end else if (adv) begin
         p3f_ff <= p3f_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p3r_ff   <= r_last;
         p3rem_ff <= {rdiff[24:0], 31'b0};
         p3num_ff <= rnum_ff[SQRT_R_STEPS-1];
      end
   end

   // sin squared division, one quotient bit per stage
   flags_type   qf_ff   [DIV_Q_STEPS];
   logic [55:0] qrem_ff [DIV_Q_STEPS];
   logic [32:0] qq_ff   [DIV_Q_STEPS];
   logic [23:0] qr_ff   [DIV_Q_STEPS];
   logic [55:0] qnum_ff [DIV_Q_STEPS];

   for (genvar j = 0; j < DIV_Q_STEPS; j++) begin : g_div_q
      flags_type   f_prev;
      logic [55:0] rem_prev, num_prev, rem_in;
      logic [32:0] q_prev, q_in;
      logic [23:0] r_prev;
      logic [56:0] dsr;

      if (j == 0) begin : g_first
         assign f_prev   = p3f_ff;
         assign rem_prev = p3rem_ff;
         assign q_prev   = '0;
         assign r_prev   = p3r_ff;
         assign num_prev = p3num_ff;
      end else begin : g_next
         assign f_prev   = qf_ff[j-1];
         assign rem_prev = qrem_ff[j-1];
         assign q_prev   = qq_ff[j-1];
         assign r_prev   = qr_ff[j-1];
         assign num_prev = qnum_ff[j-1];
      end

      always_comb begin
         dsr = 57'(r_prev) << (DIV_Q_STEPS - 1 - j);
         if ({1'b0, rem_prev} >= dsr) begin
            rem_in = rem_prev - dsr[55:0];
            q_in   = {q_prev[31:0], 1'b1};
         end else begin
            rem_in = rem_prev;
            q_in   = {q_prev[31:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            qf_ff[j].valid <= 1'b0;
         end else if (adv) begin
            qf_ff[j] <= f_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            qrem_ff[j] <= rem_in;
            qq_ff[j]   <= q_in;
            qr_ff[j]   <= r_prev;
            qnum_ff[j] <= num_prev;
         end
      end
   end

   // sine square root, one result bit per stage
   flags_type   sf_ff   [SQRT_S_STEPS];
   logic [62:0] sv_ff   [SQRT_S_STEPS];
   logic [62:0] ss_ff   [SQRT_S_STEPS];
   logic [23:0] sr_ff   [SQRT_S_STEPS];
   logic [55:0] snum_ff [SQRT_S_STEPS];

   for (genvar k = 0; k < SQRT_S_STEPS; k++) begin : g_sqrt_s
      localparam logic [62:0] Bit = 63'(1) << (62 - 2 * k);
      flags_type   f_prev;
      logic [62:0] v_prev, s_prev, trial, v_in, s_in;
      logic [23:0] r_prev;
      logic [55:0] num_prev;

      if (k == 0) begin : g_first
         assign f_prev   = qf_ff[DIV_Q_STEPS-1];
         assign v_prev   = {qq_ff[DIV_Q_STEPS-1], 30'b0};
         assign s_prev   = '0;
         assign r_prev   = qr_ff[DIV_Q_STEPS-1];
         assign num_prev = qnum_ff[DIV_Q_STEPS-1];
      end else begin : g_next
         assign f_prev   = sf_ff[k-1];
         assign v_prev   = sv_ff[k-1];
         assign s_prev   = ss_ff[k-1];
         assign r_prev   = sr_ff[k-1];
         assign num_prev = snum_ff[k-1];
      end

      always_comb begin
         trial = s_prev + Bit;
         if (v_prev >= trial) begin
            v_in = v_prev - trial;
            s_in = (s_prev >> 1) + Bit;
         end else begin
            v_in = v_prev;
            s_in = s_prev >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sf_ff[k].valid <= 1'b0;
         end else if (adv) begin
            sf_ff[k] <= f_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            sv_ff[k]   <= v_in;
            ss_ff[k]   <= s_in;
            sr_ff[k]   <= r_prev;
            snum_ff[k] <= num_prev;
         end
      end
   end

   // stage 4: half denominator product, zero sine check
   logic [31:0] s_last;
   logic [24:0] path_len;
   flags_type   p4f_ff, p4f_in;
   logic [56:0] p4dh_ff;
   logic [55:0] p4num_ff;

   assign s_last   = ss_ff[SQRT_S_STEPS-1][31:0];
   assign path_len = 25'(moderator_distance_ff) + 25'(sr_ff[SQRT_S_STEPS-1]);

   always_comb begin
      p4f_in = sf_ff[SQRT_S_STEPS-1];
      p4f_in.zero_angle = p4f_in.zero_angle || s_last == '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p4f_ff.valid <= 1'b0;
      end else if (adv) begin
         p4f_ff <= p4f_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p4dh_ff  <= 57'(path_len) * 57'(s_last);
         p4num_ff <= snum_ff[SQRT_S_STEPS-1];
      end
   end

   // stage 5: overflow check
   logic [62:0] rem_start;
   logic [62:0] den_wide;
   flags_type   p5f_ff;
   logic        p5ovf_ff;
   logic [57:0] p5rem_ff, p5den_ff;

   assign rem_start = {p4num_ff, 7'b0};
   assign den_wide  = {5'b0, p4dh_ff, 1'b0};

   always_ff @(posedge clock) begin
      if (reset) begin
         p5f_ff.valid <= 1'b0;
      end else if (adv) begin
         p5f_ff <= p4f_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p5ovf_ff <= rem_start >= den_wide;
         p5rem_ff <= rem_start[57:0];
         p5den_ff <= den_wide[57:0];
      end
   end

   // d-spacing division, one quotient bit per stage
   flags_type   df_ff   [DIV_D_STEPS];
   logic        dovf_ff [DIV_D_STEPS];
   logic [57:0] drem_ff [DIV_D_STEPS];
   logic [57:0] dden_ff [DIV_D_STEPS];
   logic [31:0] dq_ff   [DIV_D_STEPS];

   for (genvar i = 0; i < DIV_D_STEPS; i++) begin : g_div_d
      flags_type   f_prev;
      logic        ovf_prev;
      logic [57:0] rem_prev, den_prev, rem_in;
      logic [58:0] shifted;
      logic [31:0] q_prev, q_in;

      if (i == 0) begin : g_first
         assign f_prev   = p5f_ff;
         assign ovf_prev = p5ovf_ff;
         assign rem_prev = p5rem_ff;
         assign den_prev = p5den_ff;
         assign q_prev   = '0;
      end else begin : g_next
         assign f_prev   = df_ff[i-1];
         assign ovf_prev = dovf_ff[i-1];
         assign rem_prev = drem_ff[i-1];
         assign den_prev = dden_ff[i-1];
         assign q_prev   = dq_ff[i-1];
      end

      always_comb begin
         shifted = {rem_prev, 1'b0};
         if (shifted >= {1'b0, den_prev}) begin
            rem_in = 58'(shifted - {1'b0, den_prev});
            q_in   = {q_prev[30:0], 1'b1};
         end else begin
            rem_in = shifted[57:0];
            q_in   = {q_prev[30:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            df_ff[i].valid <= 1'b0;
         end else if (adv) begin
            df_ff[i] <= f_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            dovf_ff[i] <= ovf_prev;
            drem_ff[i] <= rem_in;
            dden_ff[i] <= den_prev;
            dq_ff[i]   <= q_in;
         end
      end
   end

   // result register
   flags_type   fin;
   logic [31:0] d_in, d_ff;
   logic [1:0]  status_in, status_ff;

   assign fin = df_ff[DIV_D_STEPS-1];

   always_comb begin
      if (fin.pixel_range) begin
         d_in      = '0;
         status_in = STATUS_PIXEL_RANGE;
      end else if (fin.zero_time || fin.zero_angle) begin
         d_in      = D_SATURATED;
         status_in = STATUS_ZERO;
      end else if (dovf_ff[DIV_D_STEPS-1]) begin
         d_in      = D_SATURATED;
         status_in = STATUS_OK;
      end else begin
         d_in      = dq_ff[DIV_D_STEPS-1];
         status_in = STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= fin.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         d_ff      <= d_in;
         status_ff <= status_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_d_spacing = d_ff;
   assign rsp_status    = status_ff;

endmodule

@@ sv/tofd_checker.sv @@
// Port-level checker for the time-of-flight to d-spacing unit, with its bind.
`timescale 1ns / 1ps
module tofd_port_checker
   import tofd_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_d_spacing,
   input logic [1:0]  rsp_status
);

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat valid after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_d_spacing) && $stable(rsp_status))
      else $error("stalled result beat changed");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty output");

   a_range_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_PIXEL_RANGE |-> rsp_d_spacing == '0)
      else $error("pixel range beat with nonzero d-spacing");

   a_zero_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_ZERO |-> rsp_d_spacing == D_SATURATED)
      else $error("zero time or angle beat not saturated");

endmodule

bind tof_event_to_d_spacing_unit tofd_port_checker u_tofd_port_checker (.*);

@@ tb/tofd_checker.sv @@
// Checker for the d-spacing unit: tracks the pixel table, predicts each result and compares.
`timescale 1ns / 1ps
module tofd_checker
   import tofd_pkg::*;
#(
   parameter int MAX_PIXELS = 131072
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_ready,
   input  logic                       req_kind,
   input  logic [19:0]                req_pixel_index,
   input  logic [23:0]                req_tof_channel,
   input  logic signed [23:0]         req_pos_x,
   input  logic signed [23:0]         req_pos_y,
   input  logic signed [23:0]         req_pos_z,
   input  logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  logic [31:0]                rsp_d_spacing,
   input  logic [1:0]                 rsp_status,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_write_data,
   output int                         fail_count,
   output int                         pending_count
);

   typedef struct packed {
      logic signed [23:0] x;
      logic signed [23:0] y;
      logic signed [23:0] z;
   } position_type;

   typedef struct packed {
      logic [31:0] d_spacing;
      logic [1:0]  status;
   } d_result_type;

   position_type  pixel_table [int];
   d_result_type  expected_d [$];
   logic [17:0]   pixel_count;
   logic [23:0]   moderator_distance;
   logic [31:0]   tof_scale;

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned root;
      longint unsigned probe;
      root  = 0;
      probe = 64'd1 << 62;
      while (probe > v) probe >>= 2;
      while (probe != 0) begin
         if (v >= root + probe) begin
            v    -= root + probe;
            root  = (root >> 1) + probe;
         end else begin
            root >>= 1;
         end
         probe >>= 2;
      end
      return root;
   endfunction

   function automatic d_result_type predict_d_spacing(logic [19:0] pix, logic [23:0] chan);
      position_type    p;
      longint          x, y, z, rx;
      longint unsigned r2, r, q, s, num, den, rem;
      logic [31:0]     quo;
      if (pix >= pixel_count || pix >= MAX_PIXELS) return '{32'd0, STATUS_PIXEL_RANGE};
      if (chan == 0) return '{D_SATURATED, STATUS_ZERO};
      p  = pixel_table[int'(pix)];
      x  = p.x;
      y  = p.y;
      z  = p.z;
      r2 = x * x + y * y + z * z;
      r  = int_sqrt(r2);
      if (r == 0) return '{D_SATURATED, STATUS_ZERO};
      rx = longint'(r) - x;
      if (rx < 0) rx = 0;
      q = (unsigned'(rx) << 31) / r;
      if (q > (64'd1 << 32)) q = 64'd1 << 32;
      s = int_sqrt(q << 30);
      if (s == 0) return '{D_SATURATED, STATUS_ZERO};
      num = 64'(tof_scale) * 64'(chan);
      den = 2 * (64'(moderator_distance) + r) * s;
      rem = num << 7;
      if (rem >= den) return '{D_SATURATED, STATUS_OK};
      quo = 0;
      for (int i = 0; i < 32; i++) begin
         rem <<= 1;
         quo <<= 1;
         if (rem >= den) begin
            rem   -= den;
            quo[0] = 1'b1;
         end
      end
      return '{quo, STATUS_OK};
   endfunction

   always @(posedge clock) begin
      d_result_type want;
      if (reset) begin
         pixel_count        = '0;
         moderator_distance = '0;
         tof_scale          = TOF_SCALE_RESET;
         expected_d.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_PIXEL_COUNT:        pixel_count        = csr_write_data[17:0];
               CSR_MODERATOR_DISTANCE: moderator_distance = csr_write_data[23:0];
               CSR_TOF_SCALE:          tof_scale          = csr_write_data;
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_d.size() == 0) begin
               $display("%0t: unexpected beat d=%h status=%0d", $time, rsp_d_spacing,
                        rsp_status);
               fail_count++;
            end else begin
               want = expected_d.pop_front();
               if (rsp_d_spacing !== want.d_spacing) begin
                  $display("%0t: d_spacing expected %h actual %h", $time, want.d_spacing,
                           rsp_d_spacing);
                  fail_count++;
               end
               if (rsp_status !== want.status) begin
                  $display("%0t: status expected %0d actual %0d", $time, want.status,
                           rsp_status);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            if (req_kind == KIND_LOAD) begin
               if (req_pixel_index < MAX_PIXELS)
                  pixel_table[int'(req_pixel_index)] = '{req_pos_x, req_pos_y, req_pos_z};
            end else begin
               expected_d.push_back(predict_d_spacing(req_pixel_index, req_tof_channel));
            end
         end
      end
      pending_count = expected_d.size();
   end

endmodule

@@ tb/tb_top.sv @@
// Testbench top for the d-spacing unit: clock, reset, stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps
module tb_top;
   import tofd_pkg::*;

   localparam int MAX_PIXELS  = 131072;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int DRAIN       = 160;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic                       req_kind = KIND_LOAD;
   logic [19:0]                req_pixel_index = '0;
   logic [23:0]                req_tof_channel = '0;
   logic signed [23:0]         req_pos_x = '0;
   logic signed [23:0]         req_pos_y = '0;
   logic signed [23:0]         req_pos_z = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic [31:0]                rsp_d_spacing;
   logic [1:0]                 rsp_status;
   logic                       csr_write_enable = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = CSR_PIXEL_COUNT;
   logic [CSR_DATA_WIDTH-1:0]  csr_write_data = '0;
   logic                       hold_go = 1'b0;
   int                         fail_count;
   int                         pending_count;
   int                         cycle_count = 0;

   bit                         loaded [MAX_PIXELS];
   int                         loaded_list [$];
   int                         burst_left = 0;
   logic [17:0]                cur_pixel_count = '0;

   tof_event_to_d_spacing_unit #(.MAX_PIXELS(MAX_PIXELS)) u_top (.*);

   tofd_checker #(.MAX_PIXELS(MAX_PIXELS)) u_checker (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tof_event_to_d_spacing_unit test failed");
         $finish;
      end
   end

   initial begin
      int mode, left, hold;
      bit held;
      left = 0;
      hold = 0;
      held = 0;
      mode = 0;
      forever begin
         @(posedge clock);
         if (hold_go && !held) begin
            held = 1;
            hold = 600;
         end
         if (hold > 0) begin
            hold--;
            rsp_ready <= 1'b0;
         end else begin
            if (left == 0) begin
               mode = $urandom_range(0, 2);
               left = $urandom_range(20, 200);
            end
            left--;
            case (mode)
               0:       rsp_ready <= 1'b1;
               1:       rsp_ready <= 1'($urandom_range(0, 1));
               default: rsp_ready <= ($urandom_range(0, 7) == 0);
            endcase
         end
      end
   end

   task automatic send_beat(logic kind, logic [19:0] pix, logic [23:0] chan,
                            logic [23:0] x, logic [23:0] y, logic [23:0] z);
      req_valid       <= 1'b1;
      req_kind        <= kind;
      req_pixel_index <= pix;
      req_tof_channel <= chan;
      req_pos_x       <= x;
      req_pos_y       <= y;
      req_pos_z       <= z;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (kind == KIND_LOAD && pix < MAX_PIXELS && !loaded[pix]) begin
         loaded[pix] = 1;
         loaded_list.push_back(int'(pix));
      end
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         if ($urandom_range(0, 2) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end else begin
         burst_left--;
      end
   endtask

   task automatic load_pixel(logic [19:0] pix, logic [23:0] x, logic [23:0] y,
                             logic [23:0] z);
      send_beat(KIND_LOAD, pix, 24'($urandom), x, y, z);
   endtask

   task automatic send_event(logic [19:0] pix, logic [23:0] chan);
      send_beat(KIND_EVENT, pix, chan, 24'($urandom), 24'($urandom), 24'($urandom));
   endtask

   task automatic drain_and_configure(logic [17:0] pc, logic [23:0] l1, logic [31:0] scale);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_PIXEL_COUNT;
      csr_write_data   <= 32'(pc);
      @(posedge clock);
      csr_index        <= CSR_MODERATOR_DISTANCE;
      csr_write_data   <= 32'(l1);
      @(posedge clock);
      csr_index        <= CSR_TOF_SCALE;
      csr_write_data   <= scale;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      cur_pixel_count = pc;
   endtask

   function automatic logic [19:0] pick_event_pixel();
      logic [19:0] pix;
      case ($urandom_range(0, 9))
         0, 1:    pix = 20'($urandom_range(0, 20'hFFFFF));
         2:       pix = (cur_pixel_count < 18'h3FFF0) ? 20'(cur_pixel_count) : 20'hFFFFF;
         default: pix = 20'(loaded_list[$urandom_range(0, loaded_list.size() - 1)]);
      endcase
      if (pix < cur_pixel_count && pix < MAX_PIXELS && !loaded[pix])
         pix = 20'(loaded_list[$urandom_range(0, loaded_list.size() - 1)]);
      return pix;
   endfunction

   function automatic logic [23:0] pick_coord(int shape);
      case (shape)
         0:       return 24'($urandom);
         1:       return 24'($signed($urandom_range(0, 24'h0A0000)) - 32'sh050000);
         default: return 24'($signed($urandom_range(0, 24'h000400)) - 32'sh000200);
      endcase
   endfunction

   initial begin
      logic [23:0] chan;
      logic [19:0] pix;
      int shape;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      drain_and_configure(18'd64, 24'h0A0000, TOF_SCALE_RESET);
      load_pixel(20'd0, 24'd0, 24'd0, 24'd0);
      load_pixel(20'd1, 24'h050000, 24'd0, 24'd0);
      load_pixel(20'd2, 24'h800000, 24'h7FFFFF, 24'h800000);
      load_pixel(20'd3, 24'h010000, 24'h020000, 24'h028000);
      load_pixel(20'd4, 24'hFFFFFF, 24'd0, 24'd0);
      load_pixel(20'd131071, 24'h7FFFFF, 24'h800000, 24'h7FFFFF);
      load_pixel(20'hFFFFF, 24'h123456, 24'h654321, 24'h0F0F0F);
      send_event(20'd0, 24'd100);
      send_event(20'd1, 24'd100);
      send_event(20'd2, 24'hFFFFFF);
      send_event(20'd3, 24'd1);
      send_event(20'd3, 24'd0);
      send_event(20'd4, 24'hFFFFFF);
      send_event(20'd64, 24'd5);
      send_event(20'hFFFFF, 24'd5);
      send_event(20'd131071, 24'd5);
      drain_and_configure(18'd131072, 24'hFFFFFF, 32'hFFFF_FFFF);
      send_event(20'd131071, 24'hFFFFFF);
      send_event(20'd2, 24'h800000);
      send_event(20'd4, 24'd1);
      send_event(20'd3, 24'h000FFF);
      drain_and_configure(18'd0, 24'd0, 32'd0);
      send_event(20'd3, 24'd9);
      drain_and_configure(18'd64, 24'd0, 32'd0);
      send_event(20'd3, 24'd9);

      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: drain_and_configure(18'd131072, 24'($urandom), TOF_SCALE_RESET);
            1: drain_and_configure(18'd256, 24'd0, $urandom);
            2: drain_and_configure(18'($urandom_range(1, 131072)), 24'hFFFFFF,
                                   32'hFFFF_FFFF);
            3: drain_and_configure(18'd0, 24'($urandom), $urandom);
            default: drain_and_configure(18'd131072, 24'($urandom), $urandom);
         endcase
         if (phase == 0) hold_go <= 1'b1;
         for (int n = 0; n < 300; n++) begin
            if ($urandom_range(0, 9) < 3) begin
               case ($urandom_range(0, 19))
                  0, 1, 2: pix = 20'($urandom_range(0, 20'hFFFFF));
                  3, 4, 5, 6: pix = 20'($urandom_range(0, MAX_PIXELS - 1));
                  default: pix = 20'($urandom_range(0, 255));
               endcase
               shape = $urandom_range(0, 2);
               if ($urandom_range(0, 9) == 0)
                  load_pixel(pix, pick_coord(shape), 24'd0, 24'd0);
               else
                  load_pixel(pix, pick_coord(shape), pick_coord(shape), pick_coord(shape));
            end else begin
               case ($urandom_range(0, 9))
                  0:       chan = 24'd0;
                  1, 2, 3: chan = 24'($urandom_range(1, 4095));
                  default: chan = 24'($urandom);
               endcase
               send_event(pick_event_pixel(), chan);
            end
         end
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      if (fail_count == 0)
         $display("tof_event_to_d_spacing_unit test passed");
      else
         $display("tof_event_to_d_spacing_unit test failed");
      $finish;
   end

endmodule

@@ filelist.f @@
sv/tofd_pkg.sv
sv/tofd_ram.sv
sv/tof_event_to_d_spacing_unit.sv
sv/tofd_checker.sv
tb/tofd_checker.sv
tb/tb_top.sv
